/* hdl/bpd_pkg.sv */
// shared types, codes and crc helper for the boot packet deframer
package bpd_pkg;

    localparam logic [7:0] START_BYTE = 8'h5a;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic [7:0] TYPE_ACK       = 8'ha1;
    localparam logic [7:0] TYPE_NAK       = 8'ha2;
    localparam logic [7:0] TYPE_ACK_ABORT = 8'ha3;
    localparam logic [7:0] TYPE_COMMAND   = 8'ha4;
    localparam logic [7:0] TYPE_DATA      = 8'ha5;
    localparam logic [7:0] TYPE_PING      = 8'ha6;
    localparam logic [7:0] TYPE_PING_RESP = 8'ha7;

    typedef enum logic [2:0] {
        KIND_ACK       = 3'd0,
        KIND_NAK       = 3'd1,
        KIND_ACK_ABORT = 3'd2,
        KIND_PING      = 3'd3,
        KIND_PING_RESP = 3'd4,
        KIND_COMMAND   = 3'd5,
        KIND_DATA      = 3'd6
    } kind_t;

    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd250;
    localparam logic [8:0] PING_RESP_LEN     = 9'd10;
    localparam logic [8:0] HDR_LEN_LO_IDX    = 9'd2;
    localparam logic [8:0] HDR_LEN_HI_IDX    = 9'd3;
    localparam logic [8:0] HDR_CRC_LO_IDX    = 9'd4;
    localparam logic [16:0] HDR_BYTES        = 17'd6;

    localparam int QUEUE_DEPTH = 4;

    // one classified byte on its way from the parser to the output stage
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  index;
        logic        last;
        logic        dropped;
        logic        check;
        logic [15:0] crc_calc;
        logic [15:0] crc_rcv;
    } rec_t;

    // msb-first crc-16 over one byte
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/bpd_front.sv */
// packet parser: hunts for frames, classifies each byte, runs the crc
module bpd_front import bpd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output rec_t       q_rec
);

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_TYPE   = 3'd1,
        ST_PINGR  = 3'd2,
        ST_HEADER = 3'd3,
        ST_BODY   = 3'd4
    } state_t;

    state_t      state_reg, state_next;
    logic [8:0]  count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcv_reg, rcv_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  max_reg;

    logic        accept;
    logic        emit;
    logic [8:0]  idx_inc;
    logic [15:0] crc_upd;
    logic [16:0] body_end;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept && emit;

    assign idx_inc  = count_reg + 9'd1;
    assign crc_upd  = crc16_next(crc_reg, s_rx_byte);
    assign body_end = {1'b0, len_reg} + HDR_BYTES;

    always_comb begin
        state_next = state_reg;
        count_next = idx_inc;
        len_next   = len_reg;
        crc_next   = crc_reg;
        rcv_next   = rcv_reg;
        kind_next  = kind_reg;
        emit       = 1'b1;

        q_rec.kind     = kind_reg;
        q_rec.data     = s_rx_byte;
        q_rec.index    = count_reg[7:0];
        q_rec.last     = 1'b0;
        q_rec.dropped  = 1'b0;
        q_rec.check    = 1'b0;
        q_rec.crc_calc = crc_reg;
        q_rec.crc_rcv  = rcv_reg;

        case (state_reg)
            ST_TYPE: begin
                count_next  = 9'd2;
                q_rec.index = 8'd1;
                case (s_rx_byte)
                    TYPE_ACK:       kind_next = KIND_ACK;
                    TYPE_NAK:       kind_next = KIND_NAK;
                    TYPE_ACK_ABORT: kind_next = KIND_ACK_ABORT;
                    TYPE_PING:      kind_next = KIND_PING;
                    TYPE_PING_RESP: kind_next = KIND_PING_RESP;
                    TYPE_COMMAND:   kind_next = KIND_COMMAND;
                    TYPE_DATA:      kind_next = KIND_DATA;
                    default:        emit = 1'b0;
                endcase
                q_rec.kind = kind_next;
                if (!emit) begin
                    // bad type byte is not retried as a start
                    kind_next  = kind_reg;
                    state_next = ST_HUNT;
                    count_next = '0;
                end else if (kind_next == KIND_PING_RESP) begin
                    state_next = ST_PINGR;
                end else if (kind_next == KIND_COMMAND || kind_next == KIND_DATA) begin
                    crc_next   = crc_upd;
                    state_next = ST_HEADER;
                end else begin
                    q_rec.last = 1'b1;
                    state_next = ST_HUNT;
                    count_next = '0;
                end
            end
            ST_PINGR: begin
                if (idx_inc >= PING_RESP_LEN) begin
                    q_rec.last = 1'b1;
                    state_next = ST_HUNT;
                    count_next = '0;
                end
            end
            ST_HEADER: begin
                if (count_reg == HDR_LEN_LO_IDX) begin
                    len_next = {8'h00, s_rx_byte};
                    crc_next = crc_upd;
                end else if (count_reg == HDR_LEN_HI_IDX) begin
                    len_next = {s_rx_byte, len_reg[7:0]};
                    crc_next = crc_upd;
                end else if (count_reg == HDR_CRC_LO_IDX) begin
                    rcv_next = {8'h00, s_rx_byte};
                end else begin
                    rcv_next      = {s_rx_byte, rcv_reg[7:0]};
                    q_rec.crc_rcv = rcv_next;
                    if (len_reg > {8'h00, max_reg}) begin
                        q_rec.last    = 1'b1;
                        q_rec.dropped = 1'b1;
                        state_next    = ST_HUNT;
                        count_next    = '0;
                    end else if (len_reg == 16'd0) begin
                        q_rec.last  = 1'b1;
                        q_rec.check = 1'b1;
                        state_next  = ST_HUNT;
                        count_next  = '0;
                    end else begin
                        state_next = ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                crc_next       = crc_upd;
                q_rec.crc_calc = crc_upd;
                if ({8'h00, idx_inc} >= body_end) begin
                    q_rec.last  = 1'b1;
                    q_rec.check = 1'b1;
                    state_next  = ST_HUNT;
                    count_next  = '0;
                end
            end
            default: begin
                emit = 1'b0;
                if (s_rx_byte == START_BYTE) begin
                    count_next = 9'd1;
                    crc_next   = crc16_next(16'h0000, s_rx_byte);
                    rcv_next   = '0;
                    len_next   = '0;
                    state_next = ST_TYPE;
                end else begin
                    count_next = count_reg;
                    state_next = ST_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            count_reg <= '0;
            len_reg   <= '0;
            crc_reg   <= '0;
            rcv_reg   <= '0;
            kind_reg  <= KIND_ACK;
            max_reg   <= MAX_PAYLOAD_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_reg <= cfg_data;
            end
            if (accept) begin
                state_reg <= state_next;
                count_reg <= count_next;
                len_reg   <= len_next;
                crc_reg   <= crc_next;
                rcv_reg   <= rcv_next;
                kind_reg  <= kind_next;
            end
        end
    end

endmodule

/* hdl/bpd_queue.sv */
// short queue of classified bytes between parser and output stage
module bpd_queue import bpd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output rec_t pop_rec,
    output logic not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rec_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_rec   = entry_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* hdl/bpd_back.sv */
// output stage: settles the crc verdict and holds the result for the sink
module bpd_back import bpd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_pop,
    input  rec_t       q_rec,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_pkt_kind,
    output logic [7:0] m_out_byte,
    output logic [7:0] m_byte_index,
    output logic       m_last,
    output logic       m_dropped,
    output logic       m_crc_ok
);

    logic       valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] byte_reg;
    logic [7:0] index_reg;
    logic       last_reg;
    logic       dropped_reg;
    logic       ok_reg;
    logic       load;

    assign load  = q_valid && (!valid_reg || m_ready);
    assign q_pop = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg    <= q_rec.kind;
            byte_reg    <= q_rec.data;
            index_reg   <= q_rec.index;
            last_reg    <= q_rec.last;
            dropped_reg <= q_rec.dropped;
            ok_reg      <= q_rec.check && (q_rec.crc_calc == q_rec.crc_rcv);
        end
    end

    assign m_valid      = valid_reg;
    assign m_pkt_kind   = kind_reg;
    assign m_out_byte   = byte_reg;
    assign m_byte_index = index_reg;
    assign m_last       = last_reg;
    assign m_dropped    = dropped_reg;
    assign m_crc_ok     = ok_reg;

endmodule

/* hdl/boot_packet_deframer_crc_check.sv */
// top level of the boot packet deframer with crc check
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  s_       | s_valid / s_ready    | s_rx_byte
//  m_       | m_valid / m_ready    | m_pkt_kind m_out_byte m_byte_index
//           |                      | m_last m_dropped m_crc_ok
//  cfg_     | cfg_valid / cfg_ready| cfg_data (max_payload)
//
// one byte per cycle while s_ready is high: the parser classifies a byte and
// updates the crc in the cycle it is taken, and a result reaches m_ through
// the queue, then the output register.
// aresetn is synchronous; it clears parser state, queue and output valid
// and sets max_payload to 250. cfg_ready is always high.
// s_ready drops only when the queue is full, which happens only while
// m_ready is held low.
module boot_packet_deframer_crc_check import bpd_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_pkt_kind,
    output logic [7:0] m_out_byte,
    output logic [7:0] m_byte_index,
    output logic       m_last,
    output logic       m_dropped,
    output logic       m_crc_ok
);

    logic q_full;
    logic q_push;
    rec_t q_in;
    logic q_pop;
    rec_t q_out;
    logic q_valid;

    bpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (q_in)
    );

    bpd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_rec  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_rec   (q_out),
        .not_empty (q_valid)
    );

    bpd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_rec        (q_out),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pkt_kind   (m_pkt_kind),
        .m_out_byte   (m_out_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last),
        .m_dropped    (m_dropped),
        .m_crc_ok     (m_crc_ok)
    );

endmodule
